### rtl/core/ntlv_pkg.sv
// ----------------------------------------------------------------------------
// ntlv_pkg
// Shared types and constants of the NDEF TLV record parser.
// ----------------------------------------------------------------------------
package ntlv_pkg;

  localparam logic [7:0] NDEF_TLV_TAG  = 8'h03;
  localparam logic [7:0] LONG_LEN_MARK = 8'hFF;
  localparam int         SR_FLAG_BIT   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESSAGE_LIMIT    = 2'd0,
    REG_URI_CAPACITY     = 2'd1,
    REG_PAYLOAD_CAPACITY = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_URI     = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_NOT_NDEF = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] message_limit;
    logic [8:0]  uri_capacity;
    logic [15:0] payload_capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       byte_kind;
    status_t     status;
    logic [7:0]  type_length;
    logic [31:0] payload_length;
    logic        last;
  } result_t;

endpackage

### rtl/core/ndef_tlv_record_parser.sv
// ----------------------------------------------------------------------------
// ndef_tlv_record_parser
// NDEF TLV record parser: tags each tag-memory byte as header, URI or payload.
// ----------------------------------------------------------------------------
// Usage:
//   Feed tag user memory one byte per request on the in_ stream, with
//   in_tuser high on the TLV tag byte to restart the parser. Each input
//   request yields exactly one result request on the out_ stream carrying the
//   byte, its kind, the parse status and the record lengths read so far;
//   out_tlast marks the byte that ends parsing (done or error).
//   An accepted byte is held in the input register, then its result is
//   captured in the result register behind the combinational step.
//   Throughput is one byte per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register takes one more request before in_tready drops.
//   Registers are written on the cfg_ channel (always ready); the user
//   must write them only while idle, as the block does not enforce it.
//   Reset clears both pipeline stages and returns the parser to idle with
//   the registers at their defaults (limit 1022, URI 64, payload 1024).
// ----------------------------------------------------------------------------
module ndef_tlv_record_parser
  import ntlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: [7:0] tag_byte
  input  logic [7:0]            in_tdata,
  // tuser: [0] first_byte
  input  logic [0:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: [7:0] out_byte, [9:8] status, [17:10] type_length,
  //        [49:18] payload_length, [55:50] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: [1:0] byte_kind
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_r,  item_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t res_r,   res_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic    advance;

  assign cfg_ready = 1'b1;

  ntlv_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ntlv_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_comb begin
    item_nxt    = item_r;
    in_vld_nxt  = in_vld_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (out_tready) out_vld_nxt = 1'b0;
    if (advance) begin
      res_nxt     = res;
      out_vld_nxt = 1'b1;
      in_vld_nxt  = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      item_nxt.tag_byte   = in_tdata;
      item_nxt.first_byte = in_tuser[0];
      in_vld_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = res_r.last;
  assign out_tuser  = res_r.byte_kind;
  assign out_tdata  = {6'd0, res_r.payload_length, res_r.type_length,
                       res_r.status, res_r.out_byte};

  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[9:8] != ST_BUSY)))
    else $error("tlast disagrees with status");

  a_data_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_HEADER) |->
      (out_tdata[9:8] == ST_BUSY || out_tdata[9:8] == ST_DONE))
    else $error("body byte carries an error status");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(item_r)))
    else $error("input stage lost a stalled request");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

### rtl/core/ntlv_cfg_regs.sv
// ----------------------------------------------------------------------------
// ntlv_cfg_regs
// Configuration register file: message limit, URI and payload capacities.
// ----------------------------------------------------------------------------
module ntlv_cfg_regs
  import ntlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MESSAGE_LIMIT:    cfg_nxt.message_limit    = wr_data;
        REG_URI_CAPACITY:     cfg_nxt.uri_capacity     = wr_data[8:0];
        REG_PAYLOAD_CAPACITY: cfg_nxt.payload_capacity = wr_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.message_limit    <= 16'd1022;
      cfg_r.uri_capacity     <= 9'd64;
      cfg_r.payload_capacity <= 16'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/ntlv_parse_core.sv
// ----------------------------------------------------------------------------
// ntlv_parse_core
// Parser state and one-byte step: computes the result of the current request
// and advances the TLV/record state when enabled.
// ----------------------------------------------------------------------------
module ntlv_parse_core
  import ntlv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_TLV_LEN    = 4'd1,
    PH_TLV_HI     = 4'd2,
    PH_TLV_LO     = 4'd3,
    PH_FLAGS      = 4'd4,
    PH_TYPE_SHORT = 4'd5,
    PH_TYPE_LONG  = 4'd6,
    PH_PAY_SHORT  = 4'd7,
    PH_PAY_LONG   = 4'd8,
    PH_URI        = 4'd9,
    PH_PAYLOAD    = 4'd10
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [15:0] tlv_len_r,   tlv_len_nxt;
  logic [7:0]  type_len_r,  type_len_nxt;
  logic [31:0] pay_len_r,   pay_len_nxt;
  logic [31:0] remain_r,    remain_nxt;
  logic [1:0]  len_idx_r,   len_idx_nxt;

  kind_t       kind;
  status_t     status;
  logic [7:0]  b;
  logic [31:0] remain_dec;
  logic        uri_ok;
  logic        pay_ok;

  assign b          = item.tag_byte;
  assign remain_dec = remain_r - 32'd1;
  assign uri_ok     = {1'b0, type_len_r} < cfg.uri_capacity;
  assign pay_ok     = (pay_len_r[31:16] == 16'd0) && (pay_len_r[15:0] < cfg.payload_capacity);

  always_comb begin
    phase_nxt    = phase_r;
    tlv_len_nxt  = tlv_len_r;
    type_len_nxt = type_len_r;
    pay_len_nxt  = pay_len_r;
    remain_nxt   = remain_r;
    len_idx_nxt  = len_idx_r;
    kind         = KIND_HEADER;
    status       = ST_BUSY;

    if (item.first_byte) begin
      tlv_len_nxt  = 16'd0;
      type_len_nxt = 8'd0;
      pay_len_nxt  = 32'd0;
      remain_nxt   = 32'd0;
      len_idx_nxt  = 2'd0;
      if (b == NDEF_TLV_TAG) begin
        phase_nxt = PH_TLV_LEN;
      end else begin
        phase_nxt = PH_IDLE;
        status    = ST_NOT_NDEF;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_IDLE;
        end
        PH_TLV_LEN: begin
          if (b == LONG_LEN_MARK) begin
            phase_nxt = PH_TLV_HI;
          end else begin
            tlv_len_nxt = {8'd0, b};
          end
        end
        PH_TLV_HI: begin
          tlv_len_nxt = {b, 8'd0};
          phase_nxt   = PH_TLV_LO;
        end
        PH_TLV_LO: begin
          tlv_len_nxt = tlv_len_r | {8'd0, b};
        end
        PH_FLAGS: begin
          phase_nxt = b[SR_FLAG_BIT] ? PH_TYPE_SHORT : PH_TYPE_LONG;
        end
        PH_TYPE_SHORT, PH_TYPE_LONG: begin
          type_len_nxt = b;
          len_idx_nxt  = 2'd0;
          pay_len_nxt  = 32'd0;
          phase_nxt    = (phase_r == PH_TYPE_SHORT) ? PH_PAY_SHORT : PH_PAY_LONG;
        end
        PH_PAY_SHORT: begin
          pay_len_nxt = {24'd0, b};
        end
        PH_PAY_LONG: begin
          pay_len_nxt = {pay_len_r[23:0], b};
          len_idx_nxt = len_idx_r + 2'd1;
        end
        PH_URI: begin
          if (uri_ok) kind = KIND_URI;
          remain_nxt = remain_dec;
          if (remain_dec == 32'd0) begin
            if (pay_len_r != 32'd0) begin
              remain_nxt = pay_len_r;
              phase_nxt  = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
              status    = ST_DONE;
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_ok) kind = KIND_PAYLOAD;
          remain_nxt = remain_dec;
          if (remain_dec == 32'd0) begin
            phase_nxt = PH_IDLE;
            status    = ST_DONE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // TLV length check once the length is complete
      if ((phase_r == PH_TLV_LEN && b != LONG_LEN_MARK) || phase_r == PH_TLV_LO) begin
        if (tlv_len_nxt >= cfg.message_limit) begin
          phase_nxt = PH_IDLE;
          status    = ST_TOO_LONG;
        end else begin
          phase_nxt = PH_FLAGS;
        end
      end

      // enter the record body after the last length byte, or finish an empty record
      if (phase_r == PH_PAY_SHORT || (phase_r == PH_PAY_LONG && len_idx_r == 2'd3)) begin
        len_idx_nxt = 2'd0;
        if (type_len_r != 8'd0) begin
          remain_nxt = {24'd0, type_len_r};
          phase_nxt  = PH_URI;
        end else if (pay_len_nxt != 32'd0) begin
          remain_nxt = pay_len_nxt;
          phase_nxt  = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_IDLE;
          status    = ST_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tlv_len_r  <= 16'd0;
      type_len_r <= 8'd0;
      pay_len_r  <= 32'd0;
      remain_r   <= 32'd0;
      len_idx_r  <= 2'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      tlv_len_r  <= tlv_len_nxt;
      type_len_r <= type_len_nxt;
      pay_len_r  <= pay_len_nxt;
      remain_r   <= remain_nxt;
      len_idx_r  <= len_idx_nxt;
    end
  end

  assign result.out_byte       = b;
  assign result.byte_kind      = kind;
  assign result.status         = status;
  assign result.type_length    = type_len_nxt;
  assign result.payload_length = pay_len_nxt;
  assign result.last           = (status != ST_BUSY);

endmodule
